// ===== hw/rtl/antialiased_disc_ring_shader_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the antialiased disc / ring shader
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_DISC_RING_SHADER_TOP_MACROS_SVH
`define ANTIALIASED_DISC_RING_SHADER_TOP_MACROS_SVH

// condition holds at every clock edge
`define ADRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ADRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/adrs_pkg.sv =====
// ----------------------------------------------------------------------------
// adrs_pkg
// Shared constants for the antialiased disc / ring shader.
// ----------------------------------------------------------------------------
package adrs_pkg;

  // default geometry
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_CENTER_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_THICKNESS = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SHAPE     = 3'd4;

  // shape modes
  localparam logic MODE_DISC = 1'b0;
  localparam logic MODE_RING = 1'b1;

  // color bytes
  localparam logic [7:0] BYTE_FULL  = 8'hFF;
  localparam logic [7:0] BYTE_EMPTY = 8'h00;

endpackage

// ===== hw/rtl/antialiased_disc_ring_shader_top.sv =====
// Throughput: one item per cycle; 3 distance stages, one square root stage per root bit,
// and 2 shading stages, all advancing together whenever the output register can move.
// Reset (rst_n low at a clock edge): pipeline emptied, registers back to center 0,
// radius 1.0, thickness 1.0, disc mode.
// ----------------------------------------------------------------------------
// antialiased_disc_ring_shader_top
// Shades one pixel per item as an antialiased disc or ring, RGBA8 out.
// ----------------------------------------------------------------------------
`include "antialiased_disc_ring_shader_top_macros.svh"

module antialiased_disc_ring_shader_top import adrs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int LEN       = COORD_BITS + FRAC_BITS,
  localparam int IN_DW     = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DW-1:0]      in_tdata,   // pixel_x, pixel_y
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // red, green, blue, alpha
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SQ_W = 2 * LEN + 1;
  localparam int RW   = (SQ_W + 1) / 2;
  localparam logic [LEN-1:0] ONE_L = LEN'(1) << FRAC_BITS;

  logic [LEN-1:0]       center_x_r, center_y_r, radius_r, thickness_r;
  logic                 shape_mode_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 adv;
  logic                 dist_vld, sqrt_vld;
  logic [SQ_W-1:0]      sum_sq;
  logic [RW-1:0]        d_root;
  logic [7:0]           rgb, alpha;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      radius_r     <= ONE_L;
      thickness_r  <= ONE_L;
      shape_mode_r <= MODE_DISC;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CENTER_X:  center_x_r   <= cfg_pwdata[LEN-1:0];
        REG_CENTER_Y:  center_y_r   <= cfg_pwdata[LEN-1:0];
        REG_RADIUS:    radius_r     <= cfg_pwdata[LEN-1:0];
        REG_THICKNESS: thickness_r  <= cfg_pwdata[LEN-1:0];
        REG_SHAPE:     shape_mode_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_CENTER_X:  cfg_prdata = APB_DATA_W'(center_x_r);
      REG_CENTER_Y:  cfg_prdata = APB_DATA_W'(center_y_r);
      REG_RADIUS:    cfg_prdata = APB_DATA_W'(radius_r);
      REG_THICKNESS: cfg_prdata = APB_DATA_W'(thickness_r);
      REG_SHAPE:     cfg_prdata = APB_DATA_W'(shape_mode_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // whole pipeline moves when the output register is empty or being taken
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  adrs_dist #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .pixel_x   (in_tdata[COORD_BITS-1:0]),
    .pixel_y   (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .out_valid (dist_vld),
    .sum_sq    (sum_sq)
  );

  adrs_sqrt #(
    .IN_W (SQ_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (dist_vld),
    .radicand  (sum_sq),
    .out_valid (sqrt_vld),
    .root      (d_root)
  );

  adrs_shade #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_shade (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (sqrt_vld),
    .d_root     (d_root),
    .radius     (radius_r),
    .thickness  (thickness_r),
    .shape_mode (shape_mode_r),
    .out_valid  (out_tvalid),
    .rgb        (rgb),
    .alpha      (alpha)
  );

  assign out_tdata = {alpha, rgb, rgb, rgb};

  // checks
  `ADRS_ASSERT_IMPL(a_rgb_binary, out_tvalid, (rgb == BYTE_FULL) || (rgb == BYTE_EMPTY),
                    "rgb byte neither full nor empty")
  `ADRS_ASSERT_IMPL(a_clear_is_transparent, out_tvalid && (rgb == BYTE_EMPTY),
                    alpha == BYTE_EMPTY, "uncovered pixel with nonzero alpha")
  `ADRS_ASSERT_IMPL(a_no_accept_on_stall, in_tvalid && in_tready, !out_tvalid || out_tready,
                    "item accepted while result stalled")
  `ADRS_ASSERT_ALWAYS(a_pready_high, cfg_pready, "config port not ready")

endmodule

// ===== hw/rtl/adrs_dist.sv =====
// ----------------------------------------------------------------------------
// adrs_dist
// Squared distance from pixel to center: abs diff, square, sum (3 stages).
// ----------------------------------------------------------------------------
module adrs_dist import adrs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int LEN       = COORD_BITS + FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [LEN-1:0]    center_x,
  input  logic [LEN-1:0]    center_y,
  output logic              out_valid,
  output logic [2*LEN:0]    sum_sq
);

  logic [LEN-1:0]   px, py, ax_nxt, ay_nxt;
  logic [LEN-1:0]   ax_r, ay_r;
  logic [2*LEN-1:0] sqx_r, sqy_r;
  logic [2*LEN:0]   sum_r;
  logic             v1_r, v2_r, v3_r;

  // pixel position in fixed point, absolute offsets
  assign px = {pixel_x, {FRAC_BITS{1'b0}}};
  assign py = {pixel_y, {FRAC_BITS{1'b0}}};
  assign ax_nxt = (px >= center_x) ? (px - center_x) : (center_x - px);
  assign ay_nxt = (py >= center_y) ? (py - center_y) : (center_y - py);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
      sum_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
    end
  end

  assign out_valid = v3_r;
  assign sum_sq    = sum_r;

endmodule

// ===== hw/rtl/adrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// adrs_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module adrs_sqrt import adrs_pkg::*; #(
  parameter int IN_W = 2 * (COORD_BITS_DEF + FRAC_BITS_DEF) + 1,
  localparam int RW  = (IN_W + 1) / 2,
  localparam int PAD = 2 * RW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [IN_W-1:0] radicand,
  output logic          out_valid,
  output logic [RW-1:0] root
);

  wire [PAD-1:0] rad_w  [0:RW-1];
  wire [RW:0]    rem_w  [0:RW-1];
  wire [RW-1:0]  root_w [0:RW];
  wire           vld_w  [0:RW];

  assign rad_w[0]  = PAD'(radicand);
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign vld_w[0]  = in_valid;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+2:0] rem_sh, trial, rem_diff;
    logic          ge;
    logic [RW-1:0] root_r;
    logic          vld_r;

    // bring down the next two radicand bits and try a one
    assign rem_sh   = {rem_w[k], rad_w[k][PAD-1 -: 2]};
    assign trial    = {1'b0, root_w[k], 2'b01};
    assign ge       = (rem_sh >= trial);
    assign rem_diff = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (adv) begin
        vld_r <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        root_r <= {root_w[k][RW-2:0], ge};
      end
    end

    assign root_w[k+1] = root_r;
    assign vld_w[k+1]  = vld_r;

    // remainder and radicand only feed later stages
    if (k < RW - 1) begin : g_carry
      logic [RW:0]    rem_r;
      logic [PAD-1:0] rad_r;

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r <= rem_diff[RW:0];
          rad_r <= {rad_w[k][PAD-3:0], 2'b00};
        end
      end

      assign rem_w[k+1] = rem_r;
      assign rad_w[k+1] = rad_r;
    end
  end

  assign root      = root_w[RW];
  assign out_valid = vld_w[RW];

endmodule

// ===== hw/rtl/adrs_shade.sv =====
// ----------------------------------------------------------------------------
// adrs_shade
// Body and edge tests against the radii, then alpha scaling (2 stages).
// ----------------------------------------------------------------------------
module adrs_shade import adrs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int LEN       = COORD_BITS + FRAC_BITS,
  localparam int RW        = LEN + 1,
  localparam int SW        = LEN + 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  logic [RW-1:0]  d_root,
  input  logic [LEN-1:0] radius,
  input  logic [LEN-1:0] thickness,
  input  logic           shape_mode,
  output logic           out_valid,
  output logic [7:0]     rgb,
  output logic [7:0]     alpha
);

  localparam logic [LEN-1:0]   ONE_L = LEN'(1) << FRAC_BITS;
  localparam logic [LEN-1:0]   TWO_L = LEN'(2) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [LEN-1:0]        ra;
  logic signed [SW-1:0]  d_s, ra_s, lr_s, e_out, e_in;
  logic                  ring, body, out_edge, in_edge;
  logic                  white_nxt, frac_nxt;
  logic [FRAC_BITS:0]    v_nxt;
  logic                  va_r, white_a_r, frac_a_r;
  logic [FRAC_BITS:0]    v_a_r;
  logic [FRAC_BITS+8:0]  prod;
  logic [7:0]            alpha_nxt;
  logic                  vb_r;
  logic [7:0]            rgb_r, alpha_r;

  // adjusted radii
  assign ring = (shape_mode == MODE_RING);
  assign ra   = (radius >= TWO_L) ? (radius - ONE_L) : ONE_L;
  assign d_s  = signed'({2'b00, d_root});
  assign ra_s = signed'({3'b000, ra});
  assign lr_s = ra_s - signed'({3'b000, thickness});

  // body and edge excesses
  assign e_out    = d_s - ra_s;
  assign e_in     = d_s - lr_s;
  assign body     = ring ? ((d_s < ra_s) && (d_s > lr_s)) : (d_s < ra_s);
  assign out_edge = (e_out[SW-1:FRAC_BITS] == '0);
  assign in_edge  = ring && (e_in[SW-1:FRAC_BITS] == '0);

  // first rule wins: inner edge, then outer edge, then body
  always_comb begin
    white_nxt = body;
    frac_nxt  = 1'b0;
    v_nxt     = '0;
    if (in_edge) begin
      white_nxt = 1'b1;
      frac_nxt  = 1'b1;
      v_nxt     = {1'b0, e_in[FRAC_BITS-1:0]};
    end else if (out_edge) begin
      white_nxt = 1'b1;
      frac_nxt  = 1'b1;
      v_nxt     = ONE_F - {1'b0, e_out[FRAC_BITS-1:0]};
    end
  end

  // coverage times 255, scaled down by the fraction width
  assign prod      = {v_a_r, 8'h00} - {8'h00, v_a_r};
  assign alpha_nxt = frac_a_r ? prod[FRAC_BITS +: 8] :
                     (white_a_r ? BYTE_FULL : BYTE_EMPTY);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      white_a_r <= white_nxt;
      frac_a_r  <= frac_nxt;
      v_a_r     <= v_nxt;
      rgb_r     <= white_a_r ? BYTE_FULL : BYTE_EMPTY;
      alpha_r   <= alpha_nxt;
    end
  end

  assign out_valid = vb_r;
  assign rgb       = rgb_r;
  assign alpha     = alpha_r;

endmodule

// ===== test/adrs_shade_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adrs_shade_checker
// Watches the pixel, result and register ports of the disc / ring shader.
// It keeps its own copy of the shape registers, predicts the RGBA8 pixel of
// every accepted coordinate and compares each result with the oldest one.
// ----------------------------------------------------------------------------
module adrs_shade_checker import adrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [23:0]           in_tdata,   // pixel_x, pixel_y
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [31:0]           out_tdata,  // red, green, blue, alpha
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    mismatch_count,
  output int                    pixels_pending
);

  localparam int CB  = COORD_BITS_DEF;
  localparam int FB  = FRAC_BITS_DEF;
  localparam int LEN = CB + FB;
  localparam longint ONE = longint'(1) << FB;

  // shadow copy of the shape registers
  logic [LEN-1:0] center_x_q;
  logic [LEN-1:0] center_y_q;
  logic [LEN-1:0] radius_q;
  logic [LEN-1:0] thickness_q;
  logic           mode_q;

  // predicted pixels, byte 0 red up to byte 3 alpha
  logic [3:0][7:0] shade_q[$];

  string chan_name[4] = '{"red", "green", "blue", "alpha"};

  // exact integer square root, floor
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem  = v;
    root = 0;
    bitv = 64'h1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // shade one pixel with the current shape registers
  function automatic logic [3:0][7:0] predict_pixel(input logic [CB-1:0] x,
                                                     input logic [CB-1:0] y);
    longint px, py, cx, cy, ax, ay, dlen, ra, lr, e;
    logic [7:0] rgb;
    logic [7:0] a;
    px = longint'(x) << FB;
    py = longint'(y) << FB;
    cx = longint'(center_x_q);
    cy = longint'(center_y_q);
    ax = (px >= cx) ? px - cx : cx - px;
    ay = (py >= cy) ? py - cy : cy - py;
    dlen = longint'(int_sqrt(longint'(ax * ax + ay * ay)));
    ra = (longint'(radius_q) >= 2 * ONE) ? longint'(radius_q) - ONE : ONE;
    lr = ra - longint'(thickness_q);
    // body coverage
    if ((mode_q == MODE_RING) ? (dlen < ra && dlen > lr) : (dlen < ra)) begin
      rgb = BYTE_FULL;
      a   = BYTE_FULL;
    end else begin
      rgb = BYTE_EMPTY;
      a   = BYTE_EMPTY;
    end
    // outer antialiased edge
    e = dlen - ra;
    if (e >= 0 && e < ONE) begin
      rgb = BYTE_FULL;
      a   = 8'(((ONE - e) * 255) >> FB);
    end
    // inner antialiased edge, ring only
    if (mode_q == MODE_RING) begin
      e = dlen - lr;
      if (e >= 0 && e < ONE) begin
        rgb = BYTE_FULL;
        a   = 8'((e * 255) >> FB);
      end
    end
    return {a, rgb, rgb, rgb};
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] shade error: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    logic [3:0][7:0] got;
    logic [3:0][7:0] want;
    if (!rst_n) begin
      center_x_q     = '0;
      center_y_q     = '0;
      radius_q       = LEN'(256);
      thickness_q    = LEN'(256);
      mode_q         = MODE_DISC;
      mismatch_count = 0;
      shade_q.delete();
    end else begin
      // register writes, unknown indexes dropped
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_CENTER_X:  center_x_q  = cfg_pwdata[LEN-1:0];
          REG_CENTER_Y:  center_y_q  = cfg_pwdata[LEN-1:0];
          REG_RADIUS:    radius_q    = cfg_pwdata[LEN-1:0];
          REG_THICKNESS: thickness_q = cfg_pwdata[LEN-1:0];
          REG_SHAPE:     mode_q      = cfg_pwdata[0];
          default: ;
        endcase
      end
      // compare an accepted result with the oldest prediction
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (shade_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no pixel pending", got));
        end else begin
          want = shade_q.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (got[f] !== want[f])
              report_mismatch($sformatf("%s got %h want %h", chan_name[f], got[f],
                                        want[f]));
          end
        end
      end
      // predict an accepted pixel
      if (in_tvalid && in_tready)
        shade_q.push_back(predict_pixel(in_tdata[CB-1:0], in_tdata[2*CB-1:CB]));
    end
    pixels_pending <= shade_q.size();
  end

endmodule

// ===== test/antialiased_disc_ring_shader_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// antialiased_disc_ring_shader_top_tb
// Drives pixel coordinates and shape settings into the disc / ring shader.
// A short directed run hits tiny radii, exact edges, a negative inner radius
// and wide register values; random phases then shade pixels around random
// discs and rings under random stalls on both streams.
// ----------------------------------------------------------------------------
module antialiased_disc_ring_shader_top_tb;
  import adrs_pkg::*;

  localparam int CB             = COORD_BITS_DEF;
  localparam int RANDOM_PIXELS  = 900;
  localparam int QUIET_FROM     = 780;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;   // pixel_x, pixel_y
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;  // red, green, blue, alpha
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int   mismatch_count;
  int   pixels_pending;
  int   random_sent;
  logic quiet;
  int   stuck_cycles;

  antialiased_disc_ring_shader_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  adrs_shade_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .pixels_pending (pixels_pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side back-pressure in short bursts
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // watchdog on cycles with no accepted item or register access
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // one register write: setup then access, then the bus goes idle
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_shape(input logic [19:0] cx, input logic [19:0] cy,
                               input logic [19:0] rad, input logic [19:0] thick,
                               input logic mode);
    cfg_write(REG_CENTER_X, 32'(cx));
    cfg_write(REG_CENTER_Y, 32'(cy));
    cfg_write(REG_RADIUS, 32'(rad));
    cfg_write(REG_THICKNESS, 32'(thick));
    cfg_write(REG_SHAPE, 32'(mode));
  endtask

  // stop sending and wait for every pixel in flight to come back
  task automatic drain_pixels();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pixels_pending != 0);
  endtask

  // send one pixel item, tvalid stays high for a following item
  task automatic send_pixel(input logic [CB-1:0] x, input logic [CB-1:0] y);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  // one random phase: new shape then pixels aimed at it
  task automatic random_phase(input int n_items);
    int         kind;
    int         span;
    logic [19:0] cx, cy, rad, thick;
    logic        mode;
    logic [CB-1:0] x, y;
    kind = $urandom_range(0, 9);
    cx   = 20'($urandom_range(0, 20'hFFFFF));
    cy   = 20'($urandom_range(0, 20'hFFFFF));
    rad  = 20'($urandom_range(0, 40 * 256));
    thick = 20'($urandom_range(0, int'(rad) + 512));
    mode = 1'($urandom_range(0, 1));
    if (kind < 6) begin
      program_shape(cx, cy, rad, thick, mode);
    end else if (kind < 8) begin
      // extreme corners of the register ranges
      cx = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
      cy = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
      case ($urandom_range(0, 4))
        0:       rad = 20'h00000;
        1:       rad = 20'h00100;
        2:       rad = 20'h001FF;
        3:       rad = 20'h00200;
        default: rad = 20'hFFFFF;
      endcase
      case ($urandom_range(0, 2))
        0:       thick = 20'h00000;
        1:       thick = 20'hFFFFF;
        default: thick = 20'($urandom_range(0, 20'hFFFFF));
      endcase
      program_shape(cx, cy, rad, thick, mode);
    end else begin
      // raw words on every index, unused ones included
      for (int r = 0; r < 8; r++) cfg_write(REG_IDX_W'(r), $urandom());
    end
    span = int'(rad >> 8) + 3;
    for (int i = 0; i < n_items; i++) begin
      if (kind < 6 && $urandom_range(0, 9) != 0) begin
        x = CB'(int'(cx >> 8) + $urandom_range(0, 2 * span) - span);
        y = CB'(int'(cy >> 8) + $urandom_range(0, 2 * span) - span);
      end else if (kind < 8 && $urandom_range(0, 1) == 0) begin
        x = cx[19] ? CB'(4095 - $urandom_range(0, 3)) : CB'($urandom_range(0, 3));
        y = cy[19] ? CB'(4095 - $urandom_range(0, 3)) : CB'($urandom_range(0, 3));
      end else begin
        x = CB'($urandom_range(0, 4095));
        y = CB'($urandom_range(0, 4095));
      end
      send_pixel(x, y);
      random_sent++;
      quiet = (random_sent >= QUIET_FROM);
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    quiet        = 1'b0;
    random_sent  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape: unit disc at the origin, plus far corners
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(1, 1);
    send_pixel(2, 0);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    drain_pixels();

    // ring with inner and outer edge hit exactly
    program_shape(20'h00000, 20'h00000, 20'h00300, 20'h00100, MODE_RING);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(1, 1);
    send_pixel(2, 0);
    send_pixel(2, 1);
    send_pixel(3, 0);
    drain_pixels();

    // wide register values, zero radius, negative inner radius, unused indexes
    cfg_write(REG_CENTER_X, 32'hFFFF_FFFF);
    cfg_write(REG_CENTER_Y, 32'hFFFF_FFFF);
    cfg_write(REG_RADIUS, 32'hFFF0_0000);
    cfg_write(REG_THICKNESS, 32'hFFFF_FFFF);
    cfg_write(REG_SHAPE, 32'hFFFF_FFFF);
    cfg_write(3'd5, 32'h0000_0300);
    cfg_write(3'd6, 32'h0000_0000);
    cfg_write(3'd7, 32'hFFFF_FFFF);
    send_pixel(4095, 4095);
    send_pixel(4095, 4094);
    send_pixel(4094, 4094);
    send_pixel(0, 0);
    drain_pixels();

    // disc with fractional center
    program_shape(20'h00A80, 20'h00A40, 20'h00500, 20'h00100, MODE_DISC);
    send_pixel(10, 10);
    send_pixel(15, 10);
    send_pixel(16, 10);
    send_pixel(10, 15);
    send_pixel(14, 14);
    send_pixel(5, 10);
    send_pixel(6, 6);
    drain_pixels();

    // random phases, each starting from an empty pipeline
    while (random_sent < RANDOM_PIXELS) begin
      random_phase($urandom_range(20, 80));
      drain_pixels();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
